// File: sv/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants of the matrix to quaternion block
// Request payloads, the classified job handed from front to back, widths.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int RAD_W     = 17;             // clamped radicand, unsigned
    localparam int DIF_W     = 17;             // sum or difference of two elements
    localparam int ROOT_W    = 16;             // floor(sqrt(rad << FRAC_BITS))
    localparam int SQ_IN_W   = 2 * ROOT_W;     // radicand scaled into Q.F squared
    localparam int NUM_W     = 31;             // mag << FRAC_BITS plus the root
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_mat;

    typedef struct packed {
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
    } t_quat;

    // Slot codes of the component that comes from the root itself.
    typedef enum logic [1:0] {
        SLOT_W = 2'd0,
        SLOT_X = 2'd1,
        SLOT_Y = 2'd2,
        SLOT_Z = 2'd3
    } t_slot;

    // One classified request: major slot, radicand and the per-slot numerators
    // (slot order w, x, y, z; the major slot's numerator is zero).
    typedef struct packed {
        t_slot                      major;
        logic [RAD_W-1:0]           rad;
        logic [3:0][DIF_W-1:0]      dif;
    } t_job;

endpackage

// File: sv/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front: input register and classification
// Picks the trace or diagonal path, forms the radicand and the numerators.
// ----------------------------------------------------------------------------
module rmq_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  rmq_pkg::t_mat   i_mat,
    output logic            o_push,
    input  logic            i_full,
    output rmq_pkg::t_job   o_job
);

    localparam logic signed [18:0] ONE = 19'sd1 <<< rmq_pkg::FRAC_BITS;

    logic          r_valid;
    rmq_pkg::t_job r_job;
    rmq_pkg::t_job n_job;
    logic          accept;

    logic signed [18:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [18:0] trace;
    logic signed [18:0] rad;

    assign a00 = 19'(i_mat.m00);
    assign a01 = 19'(i_mat.m01);
    assign a02 = 19'(i_mat.m02);
    assign a10 = 19'(i_mat.m10);
    assign a11 = 19'(i_mat.m11);
    assign a12 = 19'(i_mat.m12);
    assign a20 = 19'(i_mat.m20);
    assign a21 = 19'(i_mat.m21);
    assign a22 = 19'(i_mat.m22);
    assign trace = a00 + a11 + a22;

    always_comb begin
        n_job.dif = '0;
        if (trace > 19'sd0) begin
            n_job.major  = rmq_pkg::SLOT_W;
            rad          = trace + ONE;
            n_job.dif[1] = 17'(a21 - a12);
            n_job.dif[2] = 17'(a02 - a20);
            n_job.dif[3] = 17'(a10 - a01);
        end else if (a11 > a00 && a22 <= a11) begin
            n_job.major  = rmq_pkg::SLOT_Y;
            rad          = a11 - a22 - a00 + ONE;
            n_job.dif[0] = 17'(a02 - a20);
            n_job.dif[1] = 17'(a01 + a10);
            n_job.dif[3] = 17'(a21 + a12);
        end else if ((a11 > a00 && a22 > a11) || (a11 <= a00 && a22 > a00)) begin
            n_job.major  = rmq_pkg::SLOT_Z;
            rad          = a22 - a00 - a11 + ONE;
            n_job.dif[0] = 17'(a10 - a01);
            n_job.dif[1] = 17'(a02 + a20);
            n_job.dif[2] = 17'(a12 + a21);
        end else begin
            n_job.major  = rmq_pkg::SLOT_X;
            rad          = a00 - a11 - a22 + ONE;
            n_job.dif[0] = 17'(a21 - a12);
            n_job.dif[2] = 17'(a10 + a01);
            n_job.dif[3] = 17'(a20 + a02);
        end
        // Radicands below one are clamped to one.
        n_job.rad = (rad < 19'sd1) ? 17'd1 : rad[16:0];
    end

    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_full;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

// File: sv/rmq_queue.sv
// ----------------------------------------------------------------------------
// rmq_queue: short job queue between front and back
// Lets each side stall on its own.
// ----------------------------------------------------------------------------
module rmq_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rmq_pkg::t_job   i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output rmq_pkg::t_job   o_job
);

    localparam int PW = $clog2(rmq_pkg::QUEUE_DEPTH);

    rmq_pkg::t_job r_mem [rmq_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;

    assign o_full  = r_cnt == (PW+1)'(rmq_pkg::QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// File: sv/rmq_back.sv
// ----------------------------------------------------------------------------
// rmq_back: pipelined square root, four lane divider and output register
// One root digit per stage, then one quotient bit per stage in every lane.
// ----------------------------------------------------------------------------
module rmq_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  rmq_pkg::t_job   i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output rmq_pkg::t_quat  o_quat
);

    localparam int RW  = rmq_pkg::ROOT_W;
    localparam int NW  = rmq_pkg::NUM_W;
    localparam int DW  = rmq_pkg::DIF_W;
    localparam int SQ  = RW;     // root stages
    localparam int DV  = NW;     // quotient stages

    typedef struct packed {
        logic                    vld;
        rmq_pkg::t_slot          major;
        logic [3:0]              neg;
        logic [3:0][DW-1:0]      mag;
        logic [rmq_pkg::SQ_IN_W-1:0] n;
        logic [RW+3:0]           rem;
        logic [RW-1:0]           root;
    } t_sq;

    typedef struct packed {
        logic                    vld;
        rmq_pkg::t_slot          major;
        logic [3:0]              neg;
        logic [RW-1:0]           root;
        logic [3:0][NW-1:0]      num;
        logic [3:0][RW+1:0]      rem;
        logic [3:0][NW-1:0]      quo;
    } t_dv;

    t_sq r_sq [SQ+1];
    t_sq n_sq [SQ+1];
    t_dv r_dv [DV+1];
    t_dv n_dv [DV+1];

    logic           en;
    logic           r_out_vld;
    rmq_pkg::t_quat r_quat;
    logic [15:0]    comp [4];

    assign en      = !(r_out_vld && i_stall);
    assign o_pop   = en && !i_empty;
    assign o_valid = r_out_vld;
    assign o_quat  = r_quat;

    // Entry of the root pipeline splits numerators into sign and magnitude,
    // then the digit-by-digit root takes one digit pair each stage.
    always_comb begin
        logic [RW+3:0] sh;
        logic [RW+3:0] trial;
        n_sq[0].vld   = !i_empty;
        n_sq[0].major = i_job.major;
        for (int l = 0; l < 4; l++) begin
            n_sq[0].neg[l] = i_job.dif[l][DW-1];
            n_sq[0].mag[l] = i_job.dif[l][DW-1] ? DW'(-i_job.dif[l]) : i_job.dif[l];
        end
        n_sq[0].n    = {{(rmq_pkg::SQ_IN_W - rmq_pkg::RAD_W - rmq_pkg::FRAC_BITS){1'b0}},
                        i_job.rad, {rmq_pkg::FRAC_BITS{1'b0}}};
        n_sq[0].rem  = '0;
        n_sq[0].root = '0;
        for (int s = 1; s <= SQ; s++) begin
            n_sq[s]   = r_sq[s-1];
            sh        = {r_sq[s-1].rem[RW+1:0], r_sq[s-1].n[rmq_pkg::SQ_IN_W-1 -: 2]};
            trial     = {r_sq[s-1].root, 2'b01};
            n_sq[s].n = r_sq[s-1].n << 2;
            if (sh >= trial) begin
                n_sq[s].rem  = sh - trial;
                n_sq[s].root = {r_sq[s-1].root[RW-2:0], 1'b1};
            end else begin
                n_sq[s].rem  = sh;
                n_sq[s].root = {r_sq[s-1].root[RW-2:0], 1'b0};
            end
        end
    end

    // Divider entry: numerator mag << F plus root gives round half away.
    // Then restoring division by twice the root, one quotient bit each stage.
    always_comb begin
        logic [RW+1:0] sh;
        logic [RW+1:0] dd;
        n_dv[0].vld   = r_sq[SQ].vld;
        n_dv[0].major = r_sq[SQ].major;
        n_dv[0].neg   = r_sq[SQ].neg;
        n_dv[0].root  = r_sq[SQ].root;
        for (int l = 0; l < 4; l++) begin
            n_dv[0].num[l] = NW'({r_sq[SQ].mag[l], {rmq_pkg::FRAC_BITS{1'b0}}})
                             + NW'(r_sq[SQ].root);
            n_dv[0].rem[l] = '0;
            n_dv[0].quo[l] = '0;
        end
        for (int s = 1; s <= DV; s++) begin
            n_dv[s] = r_dv[s-1];
            dd      = {1'b0, r_dv[s-1].root, 1'b0};
            for (int l = 0; l < 4; l++) begin
                sh                = {r_dv[s-1].rem[l][RW:0], r_dv[s-1].num[l][NW-1]};
                n_dv[s].num[l]    = r_dv[s-1].num[l] << 1;
                if (sh >= dd) begin
                    n_dv[s].rem[l] = sh - dd;
                    n_dv[s].quo[l] = {r_dv[s-1].quo[l][NW-2:0], 1'b1};
                end else begin
                    n_dv[s].rem[l] = sh;
                    n_dv[s].quo[l] = {r_dv[s-1].quo[l][NW-2:0], 1'b0};
                end
            end
        end
    end

    // Saturation and selection of the major slot.
    always_comb begin
        logic [RW:0] half;
        half = ({1'b0, r_dv[DV].root} + 1'b1) >> 1;
        for (int l = 0; l < 4; l++) begin
            if (rmq_pkg::t_slot'(l) == r_dv[DV].major) begin
                comp[l] = 16'(half);
            end else if (!r_dv[DV].neg[l]) begin
                comp[l] = (r_dv[DV].quo[l] > NW'(32767)) ? 16'h7fff : r_dv[DV].quo[l][15:0];
            end else begin
                comp[l] = (r_dv[DV].quo[l] > NW'(32768)) ? 16'h8000
                                                        : 16'(-r_dv[DV].quo[l][15:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= SQ; s++) begin
                r_sq[s].vld <= 1'b0;
            end
            for (int s = 0; s <= DV; s++) begin
                r_dv[s].vld <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (en) begin
            for (int s = 0; s <= SQ; s++) begin
                r_sq[s] <= n_sq[s];
            end
            for (int s = 0; s <= DV; s++) begin
                r_dv[s] <= n_dv[s];
            end
            r_quat.qw <= comp[0];
            r_quat.qx <= comp[1];
            r_quat.qy <= comp[2];
            r_quat.qz <= comp[3];
            r_out_vld <= r_dv[DV].vld;
        end
    end

endmodule

// File: sv/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: 3x3 rotation matrix to unit quaternion
// Q2.14 matrix requests in, Q2.14 quaternion requests out, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
// A matrix request (i_mat, nine signed Q2.14 elements) is taken on a rising
// edge where i_valid is high and o_stall is low. Each request yields exactly
// one quaternion request on o_quat (qw, qx, qy, qz), taken by the receiver on
// an edge where o_valid is high and i_stall is low; results keep input order.
// Throughput is one request per cycle while the receiver does not stall. The
// path from acceptance to o_valid runs through the front register, the queue,
// the root pipeline (entry plus one digit a stage), the divider (entry plus
// one quotient bit a stage, four lanes side by side) and the output register.
// Latency is set by the root and quotient bit counts.
// The front classifies the request (trace or largest-diagonal path) and
// pushes a job into a four-entry queue. When the receiver stalls, the whole
// back pipeline freezes in place; the queue then fills and the front raises
// o_stall only once the queue is full and its own register is occupied.
// Synchronous active-low reset empties the queue and clears every valid bit;
// the data registers are not reset and keep their contents.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  rmq_pkg::t_mat   i_mat,
    output logic            o_valid,
    input  logic            i_stall,
    output rmq_pkg::t_quat  o_quat
);

    // Front to queue.
    logic          push;
    logic          full;
    rmq_pkg::t_job front_job;

    // Queue to back.
    logic          pop;
    logic          empty;
    rmq_pkg::t_job head_job;

    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_mat   (i_mat),
        .o_push  (push),
        .i_full  (full),
        .o_job   (front_job)
    );

    rmq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (head_job)
    );

    rmq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_quat  (o_quat)
    );

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the matrix to quaternion block
// Drives matrix requests with random gaps and stalls, predicts each
// quaternion in fixed point and compares every result field in order.
// ----------------------------------------------------------------------------

// Holds the quaternions that accepted matrices must produce, oldest first.
class quat_scoreboard;
    rmq_pkg::t_quat pending[$];
    int             errors;
    int             matched;

    function automatic logic [63:0] isqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clip(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic longint root_q(longint r);
        if (r < 1) r = 1;
        return longint'(isqrt(64'(r) << rmq_pkg::FRAC_BITS));
    endfunction

    // d * 2^(F-1) / root, rounded half away from zero, saturated.
    function automatic logic signed [15:0] ratio(longint d, longint root);
        longint mag;
        longint q;
        mag = (d < 0) ? -d : d;
        q   = (2 * (mag << (rmq_pkg::FRAC_BITS - 1)) + root) / (2 * root);
        if (q > 40000) q = 40000;
        return clip((d < 0) ? -q : q);
    endfunction

    function automatic rmq_pkg::t_quat predict(rmq_pkg::t_mat mt);
        longint m[3][3];
        logic signed [15:0] q[4];
        longint one;
        longint tr;
        longint root;
        int i;
        int j;
        int k;
        rmq_pkg::t_quat res;
        one = longint'(1) << rmq_pkg::FRAC_BITS;
        m[0][0] = longint'(mt.m00); m[0][1] = longint'(mt.m01); m[0][2] = longint'(mt.m02);
        m[1][0] = longint'(mt.m10); m[1][1] = longint'(mt.m11); m[1][2] = longint'(mt.m12);
        m[2][0] = longint'(mt.m20); m[2][1] = longint'(mt.m21); m[2][2] = longint'(mt.m22);
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
            root = root_q(tr + one);
            q[0] = clip((root + 1) >>> 1);
            q[1] = ratio(m[2][1] - m[1][2], root);
            q[2] = ratio(m[0][2] - m[2][0], root);
            q[3] = ratio(m[1][0] - m[0][1], root);
        end else begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            root = root_q(m[i][i] - m[j][j] - m[k][k] + one);
            q[1 + i] = clip((root + 1) >>> 1);
            q[0]     = ratio(m[k][j] - m[j][k], root);
            q[1 + j] = ratio(m[j][i] + m[i][j], root);
            q[1 + k] = ratio(m[k][i] + m[i][k], root);
        end
        res.qw = q[0]; res.qx = q[1]; res.qy = q[2]; res.qz = q[3];
        return res;
    endfunction

    function void note_matrix(rmq_pkg::t_mat mt);
        pending.push_back(predict(mt));
    endfunction

    function void check_quat(rmq_pkg::t_quat got);
        rmq_pkg::t_quat exp_q;
        if (pending.size() == 0) begin
            $error("unexpected quaternion %h", got);
            errors++;
            return;
        end
        exp_q = pending.pop_front();
        if (got.qw !== exp_q.qw) begin
            $error("qw expected %0d actual %0d", exp_q.qw, got.qw); errors++;
        end
        if (got.qx !== exp_q.qx) begin
            $error("qx expected %0d actual %0d", exp_q.qx, got.qx); errors++;
        end
        if (got.qy !== exp_q.qy) begin
            $error("qy expected %0d actual %0d", exp_q.qy, got.qy); errors++;
        end
        if (got.qz !== exp_q.qz) begin
            $error("qz expected %0d actual %0d", exp_q.qz, got.qz); errors++;
        end
        matched++;
    endfunction
endclass

module tb_top;

    localparam int WATCHDOG = 20000;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            o_stall;
    rmq_pkg::t_mat   i_mat = '0;
    logic            o_valid;
    logic            i_stall = 1'b0;
    rmq_pkg::t_quat  o_quat;

    // Idle rates out of a hundred for sender and receiver, and a long hold.
    int     send_idle = 0;
    int     recv_idle = 0;
    bit     hold_recv = 1'b0;
    int     quiet = 0;
    quat_scoreboard board;

    rotation_matrix_to_quaternion uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Results are checked at the rising edge where the handshake completes.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) board.check_quat(o_quat);
        if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall))) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > WATCHDOG) begin
            $display("rotation_matrix_to_quaternion test failed");
            $finish;
        end
    end

    // The receiver stalls at random, or the whole time during a long hold.
    always @(negedge i_clk) begin
        i_stall <= hold_recv || ($urandom_range(99) < recv_idle);
    end

    function automatic logic signed [15:0] elem();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(2 * 16384) - 16384);
            default: return 16'($urandom());
        endcase
    endfunction

    // A rotation-like matrix: random elements, small noise on m01 and m20 only,
    // and m00 near one for one axis pick in four, so each diagonal path is taken.
    function automatic rmq_pkg::t_mat rot_like();
        rmq_pkg::t_mat mt;
        int   ax;
        ax = int'($urandom_range(3));
        mt = '0;
        mt.m00 = 16'($urandom_range(32768) - 16384);
        mt.m11 = 16'($urandom_range(32768) - 16384);
        mt.m22 = 16'($urandom_range(32768) - 16384);
        mt.m01 = 16'($urandom_range(2000) - 1000);
        mt.m10 = 16'($urandom_range(32768) - 16384);
        mt.m02 = 16'($urandom_range(32768) - 16384);
        mt.m20 = 16'($urandom_range(2000) - 1000);
        mt.m12 = 16'($urandom_range(32768) - 16384);
        mt.m21 = 16'($urandom_range(32768) - 16384);
        if (ax == 0) mt.m00 = 16'(16384 - $urandom_range(50));
        return mt;
    endfunction

    // One request: optional random gap, then valid held until accepted.
    task automatic send_matrix(rmq_pkg::t_mat mt);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_mat   <= mt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_matrix(mt);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    task automatic random_phase(int count);
        rmq_pkg::t_mat mt;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 70) mt = rot_like();
            else begin
                mt.m00 = elem(); mt.m01 = elem(); mt.m02 = elem();
                mt.m10 = elem(); mt.m11 = elem(); mt.m12 = elem();
                mt.m20 = elem(); mt.m21 = elem(); mt.m22 = elem();
            end
            send_matrix(mt);
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        rmq_pkg::t_mat mt;
        board = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: identity, trace path; zero trace; each axis major;
        // diagonal ties; malformed matrices; extremes.
        mt = '0; mt.m00 = 16384; mt.m11 = 16384; mt.m22 = 16384; send_matrix(mt);
        mt = '0; mt.m00 = 16384; mt.m11 = -16384; send_matrix(mt);
        mt = '0; mt.m00 = 16384; mt.m11 = -16384; mt.m22 = -16384; send_matrix(mt);
        mt = '0; mt.m11 = 16384; mt.m00 = -16384; mt.m22 = -16384; send_matrix(mt);
        mt = '0; mt.m22 = 16384; mt.m00 = -16384; mt.m11 = -16384; send_matrix(mt);
        mt = '0; mt.m00 = -8192; mt.m11 = -8192; mt.m22 = -8192; send_matrix(mt);
        mt = '0; mt.m00 = -100; mt.m11 = -100; mt.m22 = -300; send_matrix(mt);
        mt = '0; mt.m00 = -16384; mt.m11 = 16384; mt.m22 = 16384; send_matrix(mt);
        mt = '0; mt.m00 = -32768; mt.m11 = -32768; mt.m22 = -32768;
        mt.m01 = 32767; mt.m10 = -32768; send_matrix(mt);
        mt = '0; mt.m00 = 32767; mt.m11 = -32768; mt.m22 = -32768; send_matrix(mt);
        mt = '0; mt.m00 = 1; mt.m01 = 32767; mt.m10 = -32768;
        mt.m02 = -32768; mt.m20 = 32767; mt.m12 = 32767; mt.m21 = -32768; send_matrix(mt);
        mt = {9{16'sh7fff}}; send_matrix(mt);
        mt = {9{16'sh8000}}; send_matrix(mt);
        mt = {9{16'shffff}}; send_matrix(mt);
        mt = {9{16'sh5555}}; send_matrix(mt);
        mt = {9{16'shaaaa}}; send_matrix(mt);
        drain();

        send_idle = 33; recv_idle = 53;
        random_phase(170);
        drain();

        // Long receiver hold while the sender keeps offering requests.
        send_idle = 0; recv_idle = 0;
        hold_recv = 1'b1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                hold_recv = 1'b0;
            end
            random_phase(90);
        join
        drain();

        send_idle = 53; recv_idle = 33;
        random_phase(130);
        drain();

        send_idle = 0; recv_idle = 0;
        random_phase(120);
        drain();
        repeat (60) @(negedge i_clk);

        $display("Checked %0d quaternions from directed, rotation-like and random",
                 board.matched);
        $display("matrices under sender gaps, receiver stalls and a long hold.");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("rotation_matrix_to_quaternion test passed");
        end else begin
            $display("rotation_matrix_to_quaternion test failed");
        end
        $finish;
    end
endmodule

// File: rotation_matrix_to_quaternion.f
sv/rmq_pkg.sv
sv/rmq_front.sv
sv/rmq_queue.sv
sv/rmq_back.sv
sv/rotation_matrix_to_quaternion.sv
test/tb_top.sv
